// ----- rtl/core/tgad_pkg.sv -----
package tgad_pkg;

  // One byte request from the file stream
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_NO_DATA    = 3'd1,
    ERR_COLORMAP   = 3'd2,
    ERR_COMPRESSED = 3'd3,
    ERR_GRAY_DEPTH = 3'd4,
    ERR_BAD_DEPTH  = 3'd5,
    ERR_TOO_LARGE  = 3'd6
  } err_t;

  // One result request
  typedef struct packed {
    kind_t       kind;
    logic [23:0] pixel_address;
    logic [31:0] pixel_value;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        has_alpha;
    err_t        error_code;
    logic        last_pixel;
  } out_t;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

endpackage

// ----- rtl/core/tgad_in_reg.sv -----
module tgad_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  tgad_pkg::in_t byte_data,
  input  logic          advance,
  output logic          q_valid,
  output tgad_pkg::in_t q_data
);

  // Hold the registered request until the parser takes it
  assign byte_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      q_data <= byte_data;
    end
  end

endmodule

// ----- rtl/core/tgad_parse.sv -----
module tgad_parse #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tgad_pkg::in_t    in_d,
  output logic             emit,
  output tgad_pkg::out_t   res,
  output tgad_pkg::phase_t phase
);

  localparam int          CW      = $clog2(MAX_DIM + 1);
  localparam logic [15:0] DIM_LIM = 16'(MAX_DIM);

  localparam logic [4:0] HDR_ID_LEN = 5'd0;
  localparam logic [4:0] HDR_TYPE   = 5'd2;
  localparam logic [4:0] HDR_W_LO   = 5'd12;
  localparam logic [4:0] HDR_W_HI   = 5'd13;
  localparam logic [4:0] HDR_H_LO   = 5'd14;
  localparam logic [4:0] HDR_H_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH  = 5'd16;
  localparam logic [4:0] HDR_DESC   = 5'd17;

  // Image type codes
  localparam logic [7:0] TGA_NO_DATA  = 8'd0;
  localparam logic [7:0] TGA_COLORMAP = 8'd1;
  localparam logic [7:0] TGA_GRAY     = 8'd3;

  tgad_pkg::phase_t phase_next;
  logic [4:0]  header_index, header_index_next;
  logic [7:0]  id_field_len, id_field_len_next;
  logic [7:0]  type_code, type_code_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [7:0]  depth_reg, depth_reg_next;
  logic [7:0]  descriptor_reg, descriptor_reg_next;
  logic [7:0]  id_remaining, id_remaining_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [31:0] pixel_accum, pixel_accum_next;
  logic [CW-1:0] col_count, col_count_next;
  logic [CW-1:0] row_count, row_count_next;
  logic [23:0] row_base, row_base_next;
  logic [23:0] bottom_base;
  logic [31:0] prod_full;

  tgad_pkg::phase_t ph;
  tgad_pkg::err_t   err;
  logic [4:0]  hidx;
  logic [31:0] acc;
  logic [31:0] val;
  logic [CW-1:0] col;
  logic [16:0] col_inc;
  logic [16:0] row_inc;

  // Base of the bottom row; height settles at least two bytes before it is used
  assign prod_full = {16'd0, height_reg - 16'd1} * {16'd0, width_reg};

  always_ff @(posedge clk) begin
    bottom_base <= prod_full[23:0];
  end

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    id_field_len_next   = id_field_len;
    type_code_next      = type_code;
    width_reg_next      = width_reg;
    height_reg_next     = height_reg;
    depth_reg_next      = depth_reg;
    descriptor_reg_next = descriptor_reg;
    id_remaining_next   = id_remaining;
    byte_in_pixel_next  = byte_in_pixel;
    pixel_accum_next    = pixel_accum;
    col_count_next      = col_count;
    row_count_next      = row_count;
    row_base_next       = row_base;
    emit                = 1'b0;
    err                 = tgad_pkg::ERR_OK;
    acc                 = pixel_accum | (32'(in_d.in_byte) << {byte_in_pixel, 3'b000});
    val                 = acc;
    col                 = col_count;
    col_inc             = 17'(col_count) + 17'd1;
    row_inc             = 17'(row_count) + 17'd1;

    res.kind          = tgad_pkg::KIND_PIXEL;
    res.pixel_address = '0;
    res.pixel_value   = '0;
    res.frame_width   = width_reg[12:0];
    res.frame_height  = height_reg[12:0];
    res.has_alpha     = (depth_reg == 8'd32);
    res.error_code    = tgad_pkg::ERR_OK;
    res.last_pixel    = 1'b0;

    // A marked first byte restarts the header parse
    ph   = in_d.first_byte ? tgad_pkg::PH_HEADER : phase;
    hidx = in_d.first_byte ? 5'd0 : header_index;

    case (ph)
      tgad_pkg::PH_HEADER: begin
        phase_next        = tgad_pkg::PH_HEADER;
        header_index_next = hidx + 5'd1;
        case (hidx)
          HDR_ID_LEN: id_field_len_next   = in_d.in_byte;
          HDR_TYPE:   type_code_next      = in_d.in_byte;
          HDR_W_LO:   width_reg_next      = {width_reg[15:8], in_d.in_byte};
          HDR_W_HI:   width_reg_next      = {in_d.in_byte, width_reg[7:0]};
          HDR_H_LO:   height_reg_next     = {height_reg[15:8], in_d.in_byte};
          HDR_H_HI:   height_reg_next     = {in_d.in_byte, height_reg[7:0]};
          HDR_DEPTH:  depth_reg_next      = in_d.in_byte;
          HDR_DESC:   descriptor_reg_next = in_d.in_byte;
          default: ;
        endcase
        if (hidx == HDR_DESC) begin
          header_index_next = 5'd0;
          emit              = 1'b1;
          if (type_code == TGA_NO_DATA) begin
            err = tgad_pkg::ERR_NO_DATA;
          end else if (type_code == TGA_COLORMAP) begin
            err = tgad_pkg::ERR_COLORMAP;
          end else if (type_code > TGA_GRAY) begin
            err = tgad_pkg::ERR_COMPRESSED;
          end else if (type_code == TGA_GRAY && depth_reg != 8'd8) begin
            err = tgad_pkg::ERR_GRAY_DEPTH;
          end else if (!(depth_reg inside {8'd8, 8'd16, 8'd24, 8'd32})) begin
            err = tgad_pkg::ERR_BAD_DEPTH;
          end else if (width_reg > DIM_LIM || height_reg > DIM_LIM) begin
            err = tgad_pkg::ERR_TOO_LARGE;
          end
          if (err != tgad_pkg::ERR_OK) begin
            phase_next     = tgad_pkg::PH_IDLE;
            res.kind       = tgad_pkg::KIND_REJECT;
            res.error_code = err;
          end else begin
            res.kind           = tgad_pkg::KIND_HEADER;
            byte_in_pixel_next = 2'd0;
            pixel_accum_next   = '0;
            col_count_next     = '0;
            row_count_next     = '0;
            id_remaining_next  = id_field_len;
            row_base_next      = (in_d.in_byte[5] || height_reg == 16'd0) ? 24'd0
                                                                          : bottom_base;
            if (width_reg == 16'd0 || height_reg == 16'd0) begin
              phase_next = tgad_pkg::PH_IDLE;
            end else if (id_field_len != 8'd0) begin
              phase_next = tgad_pkg::PH_SKIP;
            end else begin
              phase_next = tgad_pkg::PH_PIXELS;
            end
          end
        end
      end
      tgad_pkg::PH_SKIP: begin
        id_remaining_next = id_remaining - 8'd1;
        if (id_remaining_next == 8'd0) begin
          phase_next = tgad_pkg::PH_PIXELS;
        end
      end
      tgad_pkg::PH_PIXELS: begin
        if (3'(byte_in_pixel) + 3'd1 < depth_reg[5:3]) begin
          byte_in_pixel_next = byte_in_pixel + 2'd1;
          pixel_accum_next   = acc;
        end else begin
          if (type_code == TGA_GRAY) begin
            val = {8'h00, acc[7:0], acc[7:0], acc[7:0]};
          end
          if (descriptor_reg[4]) begin
            col = width_reg[CW-1:0] - CW'(1) - col_count;
          end
          emit               = 1'b1;
          res.kind           = tgad_pkg::KIND_PIXEL;
          res.pixel_address  = row_base + 24'(col);
          res.pixel_value    = val;
          res.last_pixel     = (row_inc == {1'b0, height_reg}) && (col_inc == {1'b0, width_reg});
          byte_in_pixel_next = 2'd0;
          pixel_accum_next   = '0;
          col_count_next     = col_inc[CW-1:0];
          if (col_inc >= {1'b0, width_reg}) begin
            col_count_next = '0;
            row_count_next = row_inc[CW-1:0];
            row_base_next  = descriptor_reg[5] ? row_base + 24'(width_reg)
                                               : row_base - 24'(width_reg);
            if (row_inc >= {1'b0, height_reg}) begin
              phase_next = tgad_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
        // Idle: drop bytes until the next file starts
        phase_next = tgad_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tgad_pkg::PH_HEADER;
      header_index   <= '0;
      id_field_len   <= '0;
      type_code      <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      depth_reg      <= '0;
      descriptor_reg <= '0;
      id_remaining   <= '0;
      byte_in_pixel  <= '0;
      pixel_accum    <= '0;
      col_count      <= '0;
      row_count      <= '0;
      row_base       <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      id_field_len   <= id_field_len_next;
      type_code      <= type_code_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      depth_reg      <= depth_reg_next;
      descriptor_reg <= descriptor_reg_next;
      id_remaining   <= id_remaining_next;
      byte_in_pixel  <= byte_in_pixel_next;
      pixel_accum    <= pixel_accum_next;
      col_count      <= col_count_next;
      row_count      <= row_count_next;
      row_base       <= row_base_next;
    end
  end

endmodule

// ----- rtl/core/tgad_out_reg.sv -----
module tgad_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           emit,
  input  tgad_pkg::out_t res,
  output logic           res_valid,
  input  logic           res_stall,
  output tgad_pkg::out_t res_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      res_data <= res;
    end
  end

endmodule

// ----- rtl/core/tga_uncompressed_decoder_top.sv -----
// Path: a byte request waits in the input register, then goes through the parser into the
//   result register. Throughput: one byte per cycle, set by the single parse step
//   between the two registers, while a full result register is not stalled.
// Reset (synchronous, active high): clears both valid flags and all parser state; the
//   parser then reads the next bytes as a header, with or without a first-byte mark.
module tga_uncompressed_decoder_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  tgad_pkg::in_t  byte_data,
  output logic           res_valid,
  input  logic           res_stall,
  output tgad_pkg::out_t res_data
);

  logic             q_valid;
  tgad_pkg::in_t    q_data;
  logic             advance;
  logic             emit;
  tgad_pkg::out_t   res;
  tgad_pkg::phase_t phase;

  // Advance the held byte whenever the result register is free or being emptied.
  // A byte that yields no result still needs the slot, which keeps results in order.
  assign advance = q_valid && (!res_valid || !res_stall);

  tgad_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .advance    (advance),
    .q_valid    (q_valid),
    .q_data     (q_data)
  );

  // Header capture, ID skip, pixel packing and address stepping: one byte per step
  tgad_parse #(
    .MAX_DIM (MAX_DIM)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .in_d  (q_data),
    .emit  (emit),
    .res   (res),
    .phase (phase)
  );

  // Hold a result while the consumer stalls; load the next one as it drains
  tgad_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .emit      (emit),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // The input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (res_valid && res_stall))
    else $error("input stalled with result register free");

  // The last pixel of an image sends the parser idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && res.kind == tgad_pkg::KIND_PIXEL && res.last_pixel)
      |=> (phase == tgad_pkg::PH_IDLE))
    else $error("parser not idle after last pixel");

  // A rejection leaves the parser idle and carries a reason
  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && res.kind == tgad_pkg::KIND_REJECT)
      |=> (phase == tgad_pkg::PH_IDLE && res_data.error_code != tgad_pkg::ERR_OK))
    else $error("rejection without idle parser or error code");

endmodule
